@@ rtl/core/anbt_pkg.sv @@
`timescale 1ns / 1ps

package anbt_pkg;

   // Table geometry: one slot is always kept free, so at most TABLE_SIZE-1 entries live.
   localparam int TABLE_SIZE = 8;
   localparam int IDX_W      = $clog2(TABLE_SIZE);
   localparam int CNT_W      = $clog2(TABLE_SIZE + 1);
   localparam logic [CNT_W-1:0] MAX_ENTRIES = CNT_W'(TABLE_SIZE - 1);

   // Payload widths.
   localparam int BYTE_W  = 8;
   localparam int STAMP_W = 32;

   // Identifier reported when no entry is nearer than the far value.
   localparam logic [BYTE_W-1:0] NONE_ID = 8'd100;

   // Configuration register indexes and reset values.
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_AGE_LIMIT      = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FAR_THRESHOLD  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FAR_VALUE      = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BLOCK_DISTANCE = 2'd3;

   localparam logic [BYTE_W-1:0] RST_AGE_LIMIT      = 8'd64;
   localparam logic [BYTE_W-1:0] RST_FAR_THRESHOLD  = 8'd70;
   localparam logic [BYTE_W-1:0] RST_FAR_VALUE      = 8'd90;
   localparam logic [BYTE_W-1:0] RST_BLOCK_DISTANCE = 8'd60;

   // One neighbor entry as held in the table.
   typedef struct packed {
      logic [BYTE_W-1:0]  ident;
      logic [BYTE_W-1:0]  distance;
      logic [BYTE_W-1:0]  status;
      logic [BYTE_W-1:0]  flagbyte;
      logic [STAMP_W-1:0] stamp;
   } entry_type;

   // Compare results of the shared evaluation unit for the entry being read.
   typedef struct packed {
      logic id_hit;
      logic stale;
      logic closer;
      logic blocks;
   } eval_type;

endpackage

@@ rtl/core/anbt_req_if.sv @@
`timescale 1ns / 1ps

interface anbt_req_if
   import anbt_pkg::*;
   ;
   logic              valid;
   logic              ready;
   logic              op;
   logic [BYTE_W-1:0] msg_id;
   logic [BYTE_W-1:0] msg_dist;
   logic [BYTE_W-1:0] msg_state;
   logic [BYTE_W-1:0] msg_tag;
   logic [BYTE_W-1:0] query_id;

   modport source (output valid, op, msg_id, msg_dist, msg_state, msg_tag, query_id,
                   input ready);
   modport sink (input valid, op, msg_id, msg_dist, msg_state, msg_tag, query_id,
                 output ready);
endinterface

@@ rtl/core/anbt_rsp_if.sv @@
`timescale 1ns / 1ps

interface anbt_rsp_if
   import anbt_pkg::*;
   ;
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] nearest_dist;
   logic [BYTE_W-1:0] nearest_id;
   logic              nearest_valid;
   logic [3:0]        entry_total;
   logic [BYTE_W-1:0] query_dist;
   logic              blocking;

   modport source (output valid, nearest_dist, nearest_id, nearest_valid, entry_total,
                   query_dist, blocking, input ready);
   modport sink (input valid, nearest_dist, nearest_id, nearest_valid, entry_total,
                 query_dist, blocking, output ready);
endinterface

@@ rtl/core/aging_neighbor_table_unit.sv @@
`timescale 1ns / 1ps

// Aging neighbor table.
// Requests arrive on req_chan (valid/ready). A request with op low is a message
// that refreshes the entry with the same identifier or appends a new one (dropped
// when seven entries are already held); op high advances time by one tick and
// purges stale entries, scanning from the last entry down and filling a hole with
// the current last entry. Every request yields exactly one response on rsp_chan
// with the nearest entry, the distance of query_id, the entry count and the
// blocking flag, all taken after the update.
// One table store with a registered read port and one compare unit are stepped by
// a sequencer, one table slot per cycle plus a move step for each purged entry; a
// priming state precedes the result scan. req_chan.ready is high only while the
// sequencer is idle, so the next request is accepted in the cycle after the response
// is loaded at the earliest; that response may wait in the output register
// meanwhile, and the block stalls in its final step if the register is still full.
// Reset empties the table, clears time and restores the configuration defaults.
module aging_neighbor_table_unit
   import anbt_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   anbt_req_if.sink             req_chan,
   anbt_rsp_if.source           rsp_chan,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [BYTE_W-1:0]    csr_wdata
);

   localparam logic [2:0] ST_IDLE      = 3'd0;
   localparam logic [2:0] ST_FIND      = 3'd1;
   localparam logic [2:0] ST_PURGE_CHK = 3'd2;
   localparam logic [2:0] ST_PURGE_MOV = 3'd3;
   localparam logic [2:0] ST_SCAN      = 3'd4;
   localparam logic [2:0] ST_DONE      = 3'd5;
   localparam logic [2:0] ST_PRIME     = 3'd6;

   // Configuration registers.
   logic [BYTE_W-1:0] age_limit_ff, far_threshold_ff, far_value_ff, block_distance_ff;

   // Sequencer and table state.
   logic [2:0]         state_ff, state_in;
   logic [CNT_W-1:0]   idx_ff, idx_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [STAMP_W-1:0] now_ff, now_in;

   // Latched request.
   logic [BYTE_W-1:0] msg_id_ff, dist_ff, status_ff, tag_ff, query_ff;

   // Scan accumulators.
   logic [BYTE_W-1:0] best_ff, best_in, best_id_ff, best_id_in, qdist_ff, qdist_in;
   logic              found_ff, found_in, qfound_ff, qfound_in, block_ff, block_in;

   // Response register.
   logic              rsp_valid_ff, rsp_valid_in, rsp_load;
   logic [BYTE_W-1:0] out_dist_ff, out_id_ff, out_qdist_ff;
   logic              out_found_ff, out_block_ff;
   logic [3:0]        out_total_ff;

   // Storage and compare unit hookup.
   logic             wr_en;
   logic [IDX_W-1:0] wr_addr, rd_addr;
   entry_type        wr_data, rd_data;
   eval_type         ev;
   logic [BYTE_W-1:0] key_id;
   logic [CNT_W-1:0]  cur, last, next_cur;
   logic              accept, go_scan;

   assign accept = req_chan.valid && req_chan.ready;
   assign req_chan.ready = (state_ff == ST_IDLE);

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         age_limit_ff      <= RST_AGE_LIMIT;
         far_threshold_ff  <= RST_FAR_THRESHOLD;
         far_value_ff      <= RST_FAR_VALUE;
         block_distance_ff <= RST_BLOCK_DISTANCE;
      end else if (csr_we) begin
         case (csr_index)
            CSR_AGE_LIMIT:      age_limit_ff      <= csr_wdata;
            CSR_FAR_THRESHOLD:  far_threshold_ff  <= csr_wdata;
            CSR_FAR_VALUE:      far_value_ff      <= csr_wdata;
            CSR_BLOCK_DISTANCE: block_distance_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Table store; only slots below the live count are ever used.
   anbt_store #(
      .WIDTH ($bits(entry_type)),
      .DEPTH (TABLE_SIZE)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign key_id = (state_ff == ST_FIND) ? msg_id_ff : query_ff;

   anbt_eval u_eval (
      .entry          (rd_data),
      .key_id         (key_id),
      .now_time       (now_ff),
      .age_limit      (age_limit_ff),
      .best_dist      (best_ff),
      .block_distance (block_distance_ff),
      .res            (ev)
   );

   // Purge cursor points one above the slot under test; last is the tail slot.
   assign cur  = idx_ff - CNT_W'(1);
   assign last = count_ff - CNT_W'(1);

   // Sequencer.
   always_comb begin
      state_in   = state_ff;
      idx_in     = idx_ff;
      count_in   = count_ff;
      now_in     = now_ff;
      best_in    = best_ff;
      best_id_in = best_id_ff;
      found_in   = found_ff;
      qdist_in   = qdist_ff;
      qfound_in  = qfound_ff;
      block_in   = block_ff;
      go_scan    = 1'b0;
      rsp_load   = 1'b0;
      wr_en      = 1'b0;
      wr_addr    = idx_ff[IDX_W-1:0];
      wr_data    = '{ident: msg_id_ff, distance: dist_ff, status: status_ff,
                     flagbyte: tag_ff, stamp: now_ff};

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_chan.op) begin
                  now_in   = now_ff + STAMP_W'(1);
                  idx_in   = count_ff;
                  state_in = ST_PURGE_CHK;
               end else begin
                  idx_in   = '0;
                  state_in = ST_FIND;
               end
            end
         end
         ST_FIND: begin
            if (idx_ff == count_ff) begin
               // No match: append unless only the spare slot is left.
               if (count_ff < MAX_ENTRIES) begin
                  wr_en    = 1'b1;
                  count_in = count_ff + CNT_W'(1);
               end
               go_scan = 1'b1;
            end else if (ev.id_hit) begin
               wr_en   = 1'b1;
               go_scan = 1'b1;
            end else begin
               idx_in = idx_ff + CNT_W'(1);
            end
         end
         ST_PURGE_CHK: begin
            if (idx_ff == '0) begin
               go_scan = 1'b1;
            end else if (cur >= count_ff) begin
               idx_in = cur;
            end else if (ev.stale) begin
               state_in = ST_PURGE_MOV;
            end else begin
               idx_in = cur;
            end
         end
         ST_PURGE_MOV: begin
            // Move the tail entry into the stale slot and shrink the table.
            wr_en    = 1'b1;
            wr_addr  = cur[IDX_W-1:0];
            wr_data  = rd_data;
            count_in = last;
            idx_in   = cur;
            state_in = ST_PURGE_CHK;
         end
         ST_PRIME: begin
            // Read of the first slot, issued after any table write has landed.
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (idx_ff == count_ff) begin
               state_in = ST_DONE;
            end else begin
               if (ev.closer) begin
                  best_in    = rd_data.distance;
                  best_id_in = rd_data.ident;
                  found_in   = 1'b1;
               end
               if (!qfound_ff && ev.id_hit) begin
                  qdist_in  = rd_data.distance;
                  qfound_in = 1'b1;
               end
               if (ev.blocks) begin
                  block_in = 1'b1;
               end
               idx_in = idx_ff + CNT_W'(1);
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Start of the result scan.
      if (go_scan) begin
         state_in   = ST_PRIME;
         idx_in     = '0;
         best_in    = far_value_ff;
         best_id_in = NONE_ID;
         found_in   = 1'b0;
         qdist_in   = far_value_ff;
         qfound_in  = 1'b0;
         block_in   = 1'b0;
      end

      // The store read is registered, so address the slot of the next step.
      next_cur = idx_in - CNT_W'(1);
      case (state_in)
         ST_PURGE_CHK: rd_addr = next_cur[IDX_W-1:0];
         ST_PURGE_MOV: rd_addr = last[IDX_W-1:0];
         default:      rd_addr = idx_in[IDX_W-1:0];
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff   <= '0;
         count_ff <= '0;
         now_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         count_ff <= count_in;
         now_ff   <= now_in;
      end
   end

   // Request payload and accumulators.
   always_ff @(posedge clock) begin
      if (accept) begin
         msg_id_ff <= req_chan.msg_id;
         dist_ff   <= (req_chan.msg_dist >= far_threshold_ff) ? far_value_ff
                                                              : req_chan.msg_dist;
         status_ff <= req_chan.msg_state;
         tag_ff    <= req_chan.msg_tag;
         query_ff  <= req_chan.query_id;
      end
      best_ff    <= best_in;
      best_id_ff <= best_id_in;
      found_ff   <= found_in;
      qdist_ff   <= qdist_in;
      qfound_ff  <= qfound_in;
      block_ff   <= block_in;
   end

   // Response register.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         out_dist_ff  <= best_ff;
         out_id_ff    <= best_id_ff;
         out_found_ff <= found_ff;
         out_total_ff <= 4'(count_ff);
         out_qdist_ff <= qdist_ff;
         out_block_ff <= block_ff;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.nearest_dist  = out_dist_ff;
   assign rsp_chan.nearest_id    = out_id_ff;
   assign rsp_chan.nearest_valid = out_found_ff;
   assign rsp_chan.entry_total   = out_total_ff;
   assign rsp_chan.query_dist    = out_qdist_ff;
   assign rsp_chan.blocking      = out_block_ff;

endmodule

@@ rtl/core/anbt_store.sv @@
`timescale 1ns / 1ps

module anbt_store #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   // Storage is not reset; the user only reads locations it has written.
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port and one registered read port; a read returns the old data
   // when both ports hit the same location in the same cycle.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/anbt_eval.sv @@
`timescale 1ns / 1ps

module anbt_eval
   import anbt_pkg::*;
(
   input  entry_type          entry,
   input  logic [BYTE_W-1:0]  key_id,
   input  logic [STAMP_W-1:0] now_time,
   input  logic [BYTE_W-1:0]  age_limit,
   input  logic [BYTE_W-1:0]  best_dist,
   input  logic [BYTE_W-1:0]  block_distance,
   output eval_type           res
);

   logic [STAMP_W-1:0] age;

   // Age wraps with the time counter, so a plain modular subtract is right.
   assign age = now_time - entry.stamp;

   always_comb begin
      res.id_hit = (entry.ident == key_id);
      res.stale  = (age > {{(STAMP_W-BYTE_W){1'b0}}, age_limit});
      res.closer = (entry.distance < best_dist);
      res.blocks = (entry.status != '0) && (entry.flagbyte == '0) &&
                   (entry.distance < block_distance);
   end

endmodule

@@ rtl/core/anbt_checker.sv @@
`timescale 1ns / 1ps

module anbt_checker
   import anbt_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [BYTE_W-1:0] nearest_id,
   input logic              nearest_valid,
   input logic [3:0]        entry_total
);

   // A request starts a multi-cycle update, so the block is busy right after.
   a_busy_after_request: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while an update was still running");

   // The table never reports more entries than it may hold.
   a_total_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> entry_total <= 4'(TABLE_SIZE - 1))
      else $error("entry count beyond table capacity");

   // With no near entry the identifier is the none marker.
   a_none_id: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !nearest_valid |-> nearest_id == NONE_ID)
      else $error("nearest identifier set without a near entry");

   // A stalled response keeps its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(entry_total) &&
                                  $stable(nearest_id))
      else $error("stalled response changed");

endmodule

bind aging_neighbor_table_unit anbt_checker u_anbt_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_chan.valid),
   .req_ready     (req_chan.ready),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .nearest_id    (rsp_chan.nearest_id),
   .nearest_valid (rsp_chan.nearest_valid),
   .entry_total   (rsp_chan.entry_total)
);

@@ tb/testbench.sv @@
`timescale 1ns / 1ps

module testbench
   import anbt_pkg::*;
   ;

   // Operation codes carried in the op field of a request.
   localparam logic OP_MESSAGE = 1'b0;
   localparam logic OP_TICK    = 1'b1;

   // Cycles without any handshake before the run is declared hung.
   localparam int unsigned STALL_LIMIT = 1000;
   localparam int unsigned PHASES = 8;
   localparam int unsigned RANDOM_PER_PHASE = 128;

   typedef struct packed {
      logic              op;
      logic [BYTE_W-1:0] msg_id;
      logic [BYTE_W-1:0] msg_dist;
      logic [BYTE_W-1:0] msg_state;
      logic [BYTE_W-1:0] msg_tag;
      logic [BYTE_W-1:0] query_id;
   } nbr_request_type;

   typedef struct packed {
      logic [BYTE_W-1:0] nearest_dist;
      logic [BYTE_W-1:0] nearest_id;
      logic              nearest_valid;
      logic [3:0]        entry_total;
      logic [BYTE_W-1:0] query_dist;
      logic              blocking;
   } nbr_report_type;

   logic clock;
   logic reset;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [BYTE_W-1:0]    csr_wdata;

   anbt_req_if req_chan ();
   anbt_rsp_if rsp_chan ();

   aging_neighbor_table_unit u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Neighbor table as the block should hold it, plus its configuration.
   entry_type          nbr_tbl [TABLE_SIZE];
   int unsigned        held = 0;
   logic [STAMP_W-1:0] now_ticks = '0;
   logic [BYTE_W-1:0]  age_lim;
   logic [BYTE_W-1:0]  far_thr;
   logic [BYTE_W-1:0]  far_val;
   logic [BYTE_W-1:0]  block_dist;

   nbr_request_type pending [$];
   nbr_report_type  expected_reports [$];
   nbr_request_type cur_request;

   int unsigned errors = 0;
   int unsigned reports_seen = 0;
   int unsigned send_gap;
   int unsigned recv_hold;
   int unsigned idle_cycles;
   int unsigned stretch_left;
   logic        quiet;

   // Applies one request to the table and returns the report the block must give.
   function automatic nbr_report_type predict_neighbors(nbr_request_type r);
      nbr_report_type     rep;
      logic [BYTE_W-1:0]  d;
      logic [STAMP_W-1:0] age;
      int unsigned        slot;
      int unsigned        k;
      int unsigned        i;
      logic               qhit;
      if (r.op == OP_MESSAGE) begin
         d = (r.msg_dist >= far_thr) ? far_val : r.msg_dist;
         slot = held;
         for (i = 0; i < held; i++) begin
            if (nbr_tbl[i].ident == r.msg_id) begin
               slot = i;
               break;
            end
         end
         // A new identifier is dropped once the table is full.
         if (slot < held || held < MAX_ENTRIES) begin
            if (slot == held) held++;
            nbr_tbl[slot] = '{ident: r.msg_id, distance: d, status: r.msg_state,
                              flagbyte: r.msg_tag, stamp: now_ticks};
         end
      end else begin
         // Purge from the top down; a stale entry is filled from the last one.
         now_ticks = now_ticks + 1;
         for (k = held; k > 0; k--) begin
            i = k - 1;
            if (i < held) begin
               age = now_ticks - nbr_tbl[i].stamp;
               if (age > STAMP_W'(age_lim)) begin
                  nbr_tbl[i] = nbr_tbl[held - 1];
                  held--;
               end
            end
         end
      end

      rep.nearest_dist  = far_val;
      rep.nearest_id    = NONE_ID;
      rep.nearest_valid = 1'b0;
      rep.query_dist    = far_val;
      rep.blocking      = 1'b0;
      qhit = 1'b0;
      for (i = 0; i < held; i++) begin
         if (nbr_tbl[i].distance < rep.nearest_dist) begin
            rep.nearest_dist  = nbr_tbl[i].distance;
            rep.nearest_id    = nbr_tbl[i].ident;
            rep.nearest_valid = 1'b1;
         end
         if (!qhit && nbr_tbl[i].ident == r.query_id) begin
            rep.query_dist = nbr_tbl[i].distance;
            qhit = 1'b1;
         end
         if (nbr_tbl[i].status != 0 && nbr_tbl[i].flagbyte == 0 &&
             nbr_tbl[i].distance < block_dist)
            rep.blocking = 1'b1;
      end
      rep.entry_total = 4'(held);
      return rep;
   endfunction

   function automatic nbr_request_type msg_request(logic [BYTE_W-1:0] id,
                                                   logic [BYTE_W-1:0] mdist,
                                                   logic [BYTE_W-1:0] st,
                                                   logic [BYTE_W-1:0] tag,
                                                   logic [BYTE_W-1:0] qid);
      return '{op: OP_MESSAGE, msg_id: id, msg_dist: mdist, msg_state: st, msg_tag: tag,
               query_id: qid};
   endfunction

   function automatic nbr_request_type tick_request(logic [BYTE_W-1:0] qid);
      return '{op: OP_TICK, msg_id: 8'($urandom), msg_dist: 8'($urandom),
               msg_state: 8'($urandom), msg_tag: 8'($urandom), query_id: qid};
   endfunction

   // Distances are either uniform or cluster around the far threshold and the blocking distance.
   function automatic logic [BYTE_W-1:0] pick_distance();
      int near;
      case ($urandom_range(0, 2))
         0: return 8'($urandom);
         1: near = int'(far_thr) + int'($urandom_range(0, 6)) - 3;
         default: near = int'(block_dist) + int'($urandom_range(0, 6)) - 3;
      endcase
      if (near < 0) near = 0;
      if (near > 255) near = 255;
      return 8'(near);
   endfunction

   // Identifiers come mostly from a small pool so that updates and a full table are common.
   function automatic nbr_request_type random_request(int unsigned tick_pct,
                                                      int unsigned id_hi);
      nbr_request_type r;
      logic [BYTE_W-1:0] qid;
      qid = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, id_hi));
      if ($urandom_range(0, 99) < tick_pct) begin
         r = tick_request(qid);
      end else begin
         r = msg_request(($urandom_range(0, 7) == 0) ? 8'($urandom)
                                                     : 8'($urandom_range(0, id_hi)),
                         pick_distance(),
                         $urandom_range(0, 1) ? 8'($urandom) : 8'h00,
                         $urandom_range(0, 1) ? 8'($urandom) : 8'h00,
                         qid);
      end
      return r;
   endfunction

   function automatic int unsigned pause_len();
      return quiet ? 0 : $urandom_range(0, 10);
   endfunction

   task automatic report_mismatch(string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      errors++;
   endtask

   task automatic compare_field(string name, logic [BYTE_W-1:0] got, logic [BYTE_W-1:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s got %0d expected %0d (report %0d)",
                                   name, got, want, reports_seen));
   endtask

   // Register write at a rising edge; the table is idle whenever this runs.
   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [BYTE_W-1:0] val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         CSR_AGE_LIMIT:      age_lim    = val;
         CSR_FAR_THRESHOLD:  far_thr    = val;
         CSR_FAR_VALUE:      far_val    = val;
         CSR_BLOCK_DISTANCE: block_dist = val;
         default: ;
      endcase
   endtask

   task automatic write_all(logic [BYTE_W-1:0] age, logic [BYTE_W-1:0] thr,
                            logic [BYTE_W-1:0] far, logic [BYTE_W-1:0] blk);
      write_reg(CSR_AGE_LIMIT, age);
      write_reg(CSR_FAR_THRESHOLD, thr);
      write_reg(CSR_FAR_VALUE, far);
      write_reg(CSR_BLOCK_DISTANCE, blk);
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic wait_drained();
      while (pending.size() != 0 || req_chan.valid || expected_reports.size() != 0)
         @(negedge clock);
   endtask

   // Clock.
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Alternate between stretches with random pauses and stretches without any.
   always @(posedge clock) begin
      if (reset) begin
         quiet        <= 1'b0;
         stretch_left <= 0;
      end else if (stretch_left == 0) begin
         quiet        <= ($urandom_range(0, 3) == 0);
         stretch_left <= $urandom_range(40, 200);
      end else begin
         stretch_left <= stretch_left - 1;
      end
   end

   // Request driver: predicts on acceptance, then presents the next queued request.
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid     <= 1'b0;
         req_chan.op        <= OP_MESSAGE;
         req_chan.msg_id    <= '0;
         req_chan.msg_dist  <= '0;
         req_chan.msg_state <= '0;
         req_chan.msg_tag   <= '0;
         req_chan.query_id  <= '0;
         send_gap           <= 0;
      end else begin
         if (req_chan.valid && req_chan.ready)
            expected_reports.push_back(predict_neighbors(cur_request));
         if (!req_chan.valid || req_chan.ready) begin
            if (send_gap != 0) begin
               send_gap       <= send_gap - 1;
               req_chan.valid <= 1'b0;
            end else if (pending.size() != 0) begin
               cur_request = pending.pop_front();
               req_chan.op        <= cur_request.op;
               req_chan.msg_id    <= cur_request.msg_id;
               req_chan.msg_dist  <= cur_request.msg_dist;
               req_chan.msg_state <= cur_request.msg_state;
               req_chan.msg_tag   <= cur_request.msg_tag;
               req_chan.query_id  <= cur_request.query_id;
               req_chan.valid     <= 1'b1;
               send_gap           <= pause_len();
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // Report monitor: checks each accepted report against the oldest prediction.
   always @(posedge clock) begin : monitor
      nbr_report_type want;
      int unsigned hold;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         recv_hold      <= 0;
      end else if (rsp_chan.valid && rsp_chan.ready) begin
         if (expected_reports.size() == 0) begin
            report_mismatch("report arrived with no request outstanding");
         end else begin
            want = expected_reports.pop_front();
            compare_field("nearest_dist", rsp_chan.nearest_dist, want.nearest_dist);
            compare_field("nearest_id", rsp_chan.nearest_id, want.nearest_id);
            compare_field("nearest_valid", BYTE_W'(rsp_chan.nearest_valid),
                          BYTE_W'(want.nearest_valid));
            compare_field("entry_total", BYTE_W'(rsp_chan.entry_total),
                          BYTE_W'(want.entry_total));
            compare_field("query_dist", rsp_chan.query_dist, want.query_dist);
            compare_field("blocking", BYTE_W'(rsp_chan.blocking), BYTE_W'(want.blocking));
         end
         reports_seen++;
         hold = pause_len();
         recv_hold      <= hold;
         rsp_chan.ready <= (hold == 0);
      end else if (recv_hold != 0) begin
         recv_hold      <= recv_hold - 1;
         rsp_chan.ready <= (recv_hold == 1);
      end else begin
         rsp_chan.ready <= 1'b1;
      end
   end

   // Watchdog on cycles without any handshake.
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("tb: failure");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Stimulus: directed requests under reset defaults, then configured random phases.
   initial begin : stimulus
      int unsigned ph;
      int unsigned n;
      int unsigned tick_pct;
      int unsigned id_hi;
      reset              = 1'b1;
      csr_we             = 1'b0;
      csr_index          = '0;
      csr_wdata          = '0;
      age_lim            = RST_AGE_LIMIT;
      far_thr            = RST_FAR_THRESHOLD;
      far_val            = RST_FAR_VALUE;
      block_dist         = RST_BLOCK_DISTANCE;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset defaults: extremes, threshold edges, blocking rules, repeats, full table.
      pending.push_back(msg_request(8'd0, 8'd0, 8'd1, 8'd0, 8'd0));
      pending.push_back(msg_request(8'd255, 8'd255, 8'd255, 8'd255, 8'd255));
      pending.push_back(msg_request(8'd0, 8'd69, 8'd0, 8'd0, 8'd0));
      pending.push_back(msg_request(8'd7, 8'd70, 8'd3, 8'd0, 8'd7));
      pending.push_back(msg_request(8'd8, 8'd59, 8'd5, 8'd0, 8'd8));
      pending.push_back(msg_request(8'd9, 8'd60, 8'd5, 8'd0, 8'd1));
      pending.push_back(msg_request(8'd10, 8'd59, 8'd5, 8'd9, 8'd10));
      pending.push_back(msg_request(8'd11, 8'd59, 8'd0, 8'd0, 8'd11));
      pending.push_back(msg_request(8'd12, 8'd1, 8'd1, 8'd0, 8'd12));
      pending.push_back(msg_request(8'd9, 8'd30, 8'd2, 8'd0, 8'd9));
      pending.push_back(msg_request(8'd10, 8'd30, 8'd2, 8'd0, 8'd10));
      pending.push_back(tick_request(8'd0));
      pending.push_back(msg_request(8'd100, 8'd0, 8'd1, 8'd0, 8'd100));
      wait_drained();

      // Purge with swap: with an age limit of one, the oldest entry goes and the last fills it.
      write_all(8'd1, RST_FAR_THRESHOLD, RST_FAR_VALUE, RST_BLOCK_DISTANCE);
      @(negedge clock);
      repeat (3) pending.push_back(tick_request(8'd0));
      pending.push_back(msg_request(8'd20, 8'd40, 8'd1, 8'd0, 8'd20));
      pending.push_back(tick_request(8'd20));
      pending.push_back(msg_request(8'd21, 8'd30, 8'd1, 8'd0, 8'd21));
      pending.push_back(msg_request(8'd22, 8'd20, 8'd0, 8'd0, 8'd22));
      pending.push_back(tick_request(8'd22));
      pending.push_back(tick_request(8'd21));
      wait_drained();

      for (ph = 0; ph < PHASES; ph++) begin
         case (ph)
            0: write_all(8'd0, 8'd255, 8'd255, 8'd255);
            1: write_all(8'd255, 8'd0, 8'd0, 8'd0);
            2: write_all(8'd64, 8'd255, 8'd0, 8'd255);
            3: write_all(8'd5, 8'd128, 8'd200, 8'd100);
            4: write_all(RST_AGE_LIMIT, RST_FAR_THRESHOLD, RST_FAR_VALUE, RST_BLOCK_DISTANCE);
            default: write_all(8'($urandom_range(0, 15)), 8'($urandom), 8'($urandom),
                               8'($urandom));
         endcase
         @(negedge clock);
         tick_pct = $urandom_range(10, 50);
         id_hi    = $urandom_range(7, 14);
         for (n = 0; n < RANDOM_PER_PHASE; n++)
            pending.push_back(random_request(tick_pct, id_hi));
         wait_drained();
      end

      // Catch any stray report before the verdict.
      repeat (30) @(negedge clock);
      if (errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

@@ sim.f @@
rtl/core/anbt_pkg.sv
rtl/core/anbt_req_if.sv
rtl/core/anbt_rsp_if.sv
rtl/core/anbt_store.sv
rtl/core/anbt_eval.sv
rtl/core/aging_neighbor_table_unit.sv
rtl/core/anbt_checker.sv
tb/testbench.sv
